// File: hdl/wtstat_pkg.sv
// ----------------------------------------------------------------------------
// wtstat_pkg
// Shared widths, defaults and register indexes for the sliding-window
// temperature statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtstat_pkg;

   // field widths
   localparam int SAMPLE_W  = 14;
   localparam int FILL_W    = 3;
   localparam int CSR_IDX_W = 2;

   // default window geometry
   localparam int WINDOW_DEF = 6;
   localparam int RECENT_DEF = 3;

   // register reset values, hundredths of a degree
   localparam logic [SAMPLE_W-1:0] FEVER_THR_RST = 14'd3850;
   localparam logic [SAMPLE_W-1:0] RISE_THR_RST  = 14'd50;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FEVER_THR = 2'd0,
      CSR_RISE_THR  = 2'd1
   } csr_index_type;

endpackage

// File: hdl/window_temperature_stats.sv
// ----------------------------------------------------------------------------
// window_temperature_stats
// Keeps the last WINDOW samples in a tap line with running sums and reports
// fever and rise flags, fill level, min, max, window mean and recent mean per sample.
// ----------------------------------------------------------------------------
// path: an accepted sample beat passes the input register, then the result
//    register, where it is held while the result channel stalls
// throughput: one sample beat per cycle unless the result channel stalls;
//    mean multipliers and min/max tree sit between tap line and result register
// reset: thresholds return to defaults, fill count, running sums and valids
//    clear; the tap line is not cleared, statistics stay zero until full
`timescale 1ns / 1ps

module window_temperature_stats #(
   parameter int WINDOW = wtstat_pkg::WINDOW_DEF,
   parameter int RECENT = wtstat_pkg::RECENT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wtstat_pkg::SAMPLE_W-1:0]      req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_fever,
   output logic                                 rsp_window_full,
   output logic [wtstat_pkg::FILL_W-1:0]        rsp_fill_level,
   output logic [wtstat_pkg::SAMPLE_W-1:0]      rsp_recent_mean,
   output logic [wtstat_pkg::SAMPLE_W-1:0]      rsp_window_min,
   output logic [wtstat_pkg::SAMPLE_W-1:0]      rsp_window_max,
   output logic [wtstat_pkg::SAMPLE_W-1:0]      rsp_window_mean,
   output logic                                 rsp_rise,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wtstat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wtstat_pkg::SAMPLE_W-1:0]      csr_wdata
);
   import wtstat_pkg::*;

   // geometry
   localparam int RECENT_USED = (RECENT < WINDOW) ? RECENT : WINDOW;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
   localparam int RSUM_W      = SAMPLE_W + $clog2(RECENT_USED);
   localparam int TREE_N      = 1 << $clog2(WINDOW);

   // reciprocal constants for exact truncating division by a constant
   localparam int SHIFT_ALL   = SUM_W + $clog2(WINDOW);
   localparam int SHIFT_REC   = RSUM_W + $clog2(RECENT_USED);
   localparam int PROD_ALL_W  = 2 * SUM_W + 1;
   localparam int PROD_REC_W  = 2 * RSUM_W + 1;
   localparam longint unsigned MUL_ALL_L =
      ((64'd1 << SHIFT_ALL) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam longint unsigned MUL_REC_L =
      ((64'd1 << SHIFT_REC) + 64'(RECENT_USED) - 64'd1) / 64'(RECENT_USED);
   localparam logic [PROD_ALL_W-1:0] MUL_ALL = PROD_ALL_W'(MUL_ALL_L);
   localparam logic [PROD_REC_W-1:0] MUL_REC = PROD_REC_W'(MUL_REC_L);

   localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(WINDOW);
   localparam logic [CNT_W-1:0] RECENT_CNT = CNT_W'(RECENT_USED);

   // registers
   logic [SAMPLE_W-1:0] fever_thr_ff, fever_thr_in;
   logic [SAMPLE_W-1:0] rise_thr_ff, rise_thr_in;
   logic [SAMPLE_W-1:0] taps_ff [WINDOW];
   logic [SAMPLE_W-1:0] taps_in [WINDOW];
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [SUM_W-1:0]    sum_all_ff, sum_all_in;
   logic [RSUM_W-1:0]   sum_rec_ff, sum_rec_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_fever_ff, s1_fever_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_fever_ff, rsp_full_ff, rsp_rise_ff;
   logic [FILL_W-1:0]   rsp_fill_ff;
   logic [SAMPLE_W-1:0] rsp_rmean_ff, rsp_min_ff, rsp_max_ff, rsp_mean_ff;

   // combinational
   logic                out_free, s1_free, req_acc, rsp_load, win_full;
   logic [SUM_W-1:0]    evict_all;
   logic [RSUM_W-1:0]   evict_rec;
   logic [SAMPLE_W-1:0] min_node [1:2*TREE_N-1];
   logic [SAMPLE_W-1:0] max_node [1:2*TREE_N-1];
   logic [SAMPLE_W-1:0] win_min, win_max, win_mean, rec_mean;
   logic [PROD_ALL_W-1:0] prod_all;
   logic [PROD_REC_W-1:0] prod_rec;
   logic [CNT_W+FILL_W-1:0] fill_wide;
   logic                win_rise;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_acc   = req_valid && s1_free;
   assign rsp_load  = s1_valid_ff && out_free;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_acc ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   assign s1_fever_in  = req_acc ? (req_sample > fever_thr_ff) : s1_fever_ff;

   // register writes
   always_comb begin
      fever_thr_in = fever_thr_ff;
      rise_thr_in  = rise_thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FEVER_THR: fever_thr_in = csr_wdata;
            CSR_RISE_THR:  rise_thr_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // tap line shift and running sums on each accepted beat
   assign evict_all = (held_ff == FULL_CNT) ? SUM_W'(taps_ff[WINDOW-1]) : '0;
   assign evict_rec = (held_ff >= RECENT_CNT) ? RSUM_W'(taps_ff[RECENT_USED-1]) : '0;

   always_comb begin
      taps_in[0] = req_acc ? req_sample : taps_ff[0];
      for (int i = 1; i < WINDOW; i++) begin
         taps_in[i] = req_acc ? taps_ff[i-1] : taps_ff[i];
      end
      held_in    = held_ff;
      sum_all_in = sum_all_ff;
      sum_rec_in = sum_rec_ff;
      if (req_acc) begin
         if (held_ff != FULL_CNT) held_in = held_ff + CNT_W'(1);
         sum_all_in = sum_all_ff + SUM_W'(req_sample) - evict_all;
         sum_rec_in = sum_rec_ff + RSUM_W'(req_sample) - evict_rec;
      end
   end

   // min and max compare tree, spare leaves copy the newest tap
   always_comb begin
      for (int i = 0; i < TREE_N; i++) begin
         min_node[TREE_N+i] = taps_ff[(i < WINDOW) ? i : 0];
         max_node[TREE_N+i] = taps_ff[(i < WINDOW) ? i : 0];
      end
      for (int i = TREE_N - 1; i >= 1; i--) begin
         min_node[i] = (min_node[2*i+1] < min_node[2*i]) ? min_node[2*i+1]
                                                         : min_node[2*i];
         max_node[i] = (max_node[2*i+1] > max_node[2*i]) ? max_node[2*i+1]
                                                         : max_node[2*i];
      end
   end

   assign win_min  = min_node[1];
   assign win_max  = max_node[1];
   assign win_rise = (win_max - win_min) > rise_thr_ff;

   // means by reciprocal multiply
   assign prod_all = PROD_ALL_W'(sum_all_ff) * MUL_ALL;
   assign prod_rec = PROD_REC_W'(sum_rec_ff) * MUL_REC;
   assign win_mean = prod_all[SHIFT_ALL +: SAMPLE_W];
   assign rec_mean = prod_rec[SHIFT_REC +: SAMPLE_W];

   assign win_full  = (held_ff == FULL_CNT);
   assign fill_wide = (CNT_W+FILL_W)'(held_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fever_thr_ff <= FEVER_THR_RST;
         rise_thr_ff  <= RISE_THR_RST;
         held_ff      <= '0;
         sum_all_ff   <= '0;
         sum_rec_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fever_thr_ff <= fever_thr_in;
         rise_thr_ff  <= rise_thr_in;
         held_ff      <= held_in;
         sum_all_ff   <= sum_all_in;
         sum_rec_ff   <= sum_rec_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: tap line and result register
   always_ff @(posedge clock) begin
      taps_ff     <= taps_in;
      s1_fever_ff <= s1_fever_in;
      if (rsp_load) begin
         rsp_fever_ff <= s1_fever_ff;
         rsp_full_ff  <= win_full;
         rsp_fill_ff  <= fill_wide[FILL_W-1:0];
         rsp_rmean_ff <= win_full ? rec_mean : '0;
         rsp_min_ff   <= win_full ? win_min  : '0;
         rsp_max_ff   <= win_full ? win_max  : '0;
         rsp_mean_ff  <= win_full ? win_mean : '0;
         rsp_rise_ff  <= win_full && win_rise;
      end
   end

   // result beat
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fever       = rsp_fever_ff;
   assign rsp_window_full = rsp_full_ff;
   assign rsp_fill_level  = rsp_fill_ff;
   assign rsp_recent_mean = rsp_rmean_ff;
   assign rsp_window_min  = rsp_min_ff;
   assign rsp_window_max  = rsp_max_ff;
   assign rsp_window_mean = rsp_mean_ff;
   assign rsp_rise        = rsp_rise_ff;

   // checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FULL_CNT)
      else $error("fill count beyond window");

   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_full_ff |->
         rsp_min_ff == '0 && rsp_max_ff == '0 && rsp_mean_ff == '0 &&
         rsp_rmean_ff == '0 && !rsp_rise_ff)
      else $error("statistics shown before window full");

   a_stat_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |->
         rsp_min_ff <= rsp_mean_ff && rsp_mean_ff <= rsp_max_ff &&
         rsp_min_ff <= rsp_rmean_ff && rsp_rmean_ff <= rsp_max_ff)
      else $error("mean outside min and max");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("sample stalled with empty first stage");

endmodule
